// File: rtl/gfpb_pkg.sv
// Shared types, constants and a helper function of the gradient fill pixel blend block.
package gfpb_pkg;

    localparam int COORD_BITS_DEF    = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CHAN_W            = 8;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ONE_Q16           = 65536;

    // atan(2^-i) in Q0.32 turns
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    localparam logic [2:0] GT_LINEAR    = 3'd0;
    localparam logic [2:0] GT_RADIAL    = 3'd1;
    localparam logic [2:0] GT_ANGLE     = 3'd2;
    localparam logic [2:0] GT_REFLECTED = 3'd3;
    localparam logic [2:0] GT_DIAMOND   = 3'd4;

    localparam logic [1:0] TM_RASTER    = 2'd0;
    localparam logic [1:0] TM_GREY_RGB  = 2'd1;
    localparam logic [1:0] TM_GREY_ONE  = 2'd2;
    localparam logic [1:0] TM_MASK      = 2'd3;

    localparam logic [1:0] CI_RED       = 2'd0;
    localparam logic [1:0] CI_GREEN     = 2'd1;
    localparam logic [1:0] CI_BLUE      = 2'd2;
    localparam logic [1:0] CI_ALPHA     = 2'd3;

    localparam logic [2:0] REG_START_POINT  = 3'd0;
    localparam logic [2:0] REG_END_POINT    = 3'd1;
    localparam logic [2:0] REG_START_COLOUR = 3'd2;
    localparam logic [2:0] REG_END_COLOUR   = 3'd3;
    localparam logic [2:0] REG_GRAD_TYPE    = 3'd4;
    localparam logic [2:0] REG_REVERSE      = 3'd5;
    localparam logic [2:0] REG_TARGET_MODE  = 3'd6;
    localparam logic [2:0] REG_COMPONENT    = 3'd7;

    typedef struct packed {
        logic [47:0] start_point;
        logic [47:0] end_point;
        logic [31:0] start_colour;
        logic [31:0] end_colour;
        logic [2:0]  gradient_type;
        logic        reverse_direction;
        logic [1:0]  target_mode;
        logic [1:0]  component_index;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] coverage;
    } pix_t;

    typedef struct packed {
        logic              changed;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } res_t;

    // floor(v/255), exact for v below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = 17'(v) + 17'd1 + 17'(v[15:8]);
        return s[15:8];
    endfunction

endpackage

// File: rtl/gradient_fill_pixel_blend.sv
// Gradient fill of a pixel stream: top level with register port and stream channels.
//
// Pixels enter on the s_ stream, one word per clock; each word carries the
// pixel position, its selection coverage and its RGBA8 value. The result word
// on the m_ stream holds the filled pixel and a changed flag, in input order.
// The gradient geometry, colours, type and target mode sit in APB registers
// at byte address 8*i; write them only while no pixel is in flight.
// From accept to a valid result, a word passes four geometry stages, the
// CORDIC pipeline of CORDIC_STAGES + 1 stages, a 17-stage ratio divider with
// one stage before and one after it, four colour stages and an 8-stage
// compositing divider, plus the output register.
// Throughput is one word per clock. The whole pipeline advances together;
// s_tready is high whenever the output register is empty or being taken, so
// a stall by the receiver freezes every stage and nothing is lost or repeated.
// Reset empties the pipeline and loads the register reset values (end colour
// all ones, everything else zero).
module gradient_fill_pixel_blend #(
    parameter int COORD_BITS    = gfpb_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = gfpb_pkg::CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // pixel in
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_x, pixel_y, coverage, in_red, in_green, in_blue, in_alpha, zero pad
    input  logic [((2*COORD_BITS+40+7)/8)*8-1:0] s_tdata,
    // pixel out
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red, out_green, out_blue, out_alpha, pixel_changed, zero pad
    output logic [39:0] m_tdata
);
    import gfpb_pkg::*;

    localparam int OFS_COV = 2 * COORD_BITS;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       ce;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_point       <= '0;
            cfg_reg.end_point         <= '0;
            cfg_reg.start_colour      <= '0;
            cfg_reg.end_colour        <= 32'hFFFF_FFFF;
            cfg_reg.gradient_type     <= GT_LINEAR;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.target_mode       <= TM_RASTER;
            cfg_reg.component_index   <= CI_RED;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_POINT:  cfg_reg.start_point       <= pwdata[47:0];
                REG_END_POINT:    cfg_reg.end_point         <= pwdata[47:0];
                REG_START_COLOUR: cfg_reg.start_colour      <= pwdata[31:0];
                REG_END_COLOUR:   cfg_reg.end_colour        <= pwdata[31:0];
                REG_GRAD_TYPE:    cfg_reg.gradient_type     <= pwdata[2:0];
                REG_REVERSE:      cfg_reg.reverse_direction <= pwdata[0];
                REG_TARGET_MODE:  cfg_reg.target_mode       <= pwdata[1:0];
                REG_COMPONENT:    cfg_reg.component_index   <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_POINT:  prdata = {16'b0, cfg_reg.start_point};
            REG_END_POINT:    prdata = {16'b0, cfg_reg.end_point};
            REG_START_COLOUR: prdata = {32'b0, cfg_reg.start_colour};
            REG_END_COLOUR:   prdata = {32'b0, cfg_reg.end_colour};
            REG_GRAD_TYPE:    prdata = {61'b0, cfg_reg.gradient_type};
            REG_REVERSE:      prdata = {63'b0, cfg_reg.reverse_direction};
            REG_TARGET_MODE:  prdata = {62'b0, cfg_reg.target_mode};
            REG_COMPONENT:    prdata = {62'b0, cfg_reg.component_index};
        endcase
    end

    // one enable for every stage: move on when the output word is free
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    pix_t                  in_pix, t_pix;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic [16:0]           t_amt;
    logic                  t_valid;
    res_t                  res;

    assign in_x            = s_tdata[COORD_BITS-1:0];
    assign in_y            = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_pix.coverage = s_tdata[OFS_COV +: 8];
    assign in_pix.red      = s_tdata[OFS_COV + 8 +: 8];
    assign in_pix.green    = s_tdata[OFS_COV + 16 +: 8];
    assign in_pix.blue     = s_tdata[OFS_COV + 24 +: 8];
    assign in_pix.alpha    = s_tdata[OFS_COV + 32 +: 8];

    gfpb_amount #(
        .COORD_BITS    (COORD_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_amount (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid && s_tready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_pix    (in_pix),
        .out_valid (t_valid),
        .out_t     (t_amt),
        .out_pix   (t_pix)
    );

    gfpb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .cfg       (cfg_reg),
        .in_valid  (t_valid),
        .in_t      (t_amt),
        .in_pix    (t_pix),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {7'b0, res.changed, res.alpha, res.blue, res.green, res.red};

endmodule

// File: rtl/gfpb_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a sideband.
module gfpb_div #(
    parameter int DEN_W  = 17,
    parameter int Q_BITS = 8,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_hi   [LANES],
    input  logic [Q_BITS-1:0] in_lo   [LANES],
    input  logic [DEN_W-1:0]  in_den  [LANES],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_BITS-1:0] out_q   [LANES],
    output logic [SIDE_W-1:0] out_side
);
    logic              v_reg    [Q_BITS];
    logic [SIDE_W-1:0] side_reg [Q_BITS];
    logic [DEN_W-1:0]  rem_reg  [Q_BITS][LANES];
    logic [Q_BITS-1:0] lo_reg   [Q_BITS][LANES];
    logic [DEN_W-1:0]  den_reg  [Q_BITS][LANES];
    logic [Q_BITS-1:0] q_reg    [Q_BITS][LANES];

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic              cur_v;
        logic [SIDE_W-1:0] cur_side;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_v    = v_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[k] <= cur_side;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W-1:0]  cur_rem;
            logic [Q_BITS-1:0] cur_lo;
            logic [DEN_W-1:0]  cur_den;
            logic [Q_BITS-1:0] cur_q;
            logic [DEN_W:0]    rem2;
            logic              take;

            if (k == 0) begin : g_first
                assign cur_rem = in_hi[l];
                assign cur_lo  = in_lo[l];
                assign cur_den = in_den[l];
                assign cur_q   = '0;
            end else begin : g_next
                assign cur_rem = rem_reg[k-1][l];
                assign cur_lo  = lo_reg[k-1][l];
                assign cur_den = den_reg[k-1][l];
                assign cur_q   = q_reg[k-1][l];
            end

            assign rem2 = {cur_rem, cur_lo[Q_BITS-1-k]};
            assign take = rem2 >= {1'b0, cur_den};

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k][l] <= take ? DEN_W'(rem2 - {1'b0, cur_den}) : DEN_W'(rem2);
                    lo_reg[k][l]  <= cur_lo;
                    den_reg[k][l] <= cur_den;
                    q_reg[k][l]   <= {cur_q[Q_BITS-2:0], take};
                end
            end

            assign out_q[l] = q_reg[Q_BITS-1][l];
        end
    end

    assign out_valid = v_reg[Q_BITS-1];
    assign out_side  = side_reg[Q_BITS-1];

endmodule

// File: rtl/gfpb_cordic.sv
// Pipelined CORDIC vectoring unit: angle in Q0.32 turns and gain-scaled magnitude per lane.
module gfpb_cordic #(
    parameter int STAGES = gfpb_pkg::CORDIC_STAGES_DEF,
    parameter int IN_W   = 26,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ce,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] in_x [LANES],
    input  logic signed [IN_W-1:0] in_y [LANES],
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [31:0]            out_ang [LANES],
    output logic [IN_W+21:0]       out_mag [LANES],
    output logic [SIDE_W-1:0]      out_side
);
    import gfpb_pkg::*;

    localparam int CW = IN_W + 23;

    logic                 v_reg    [STAGES+1];
    logic [SIDE_W-1:0]    side_reg [STAGES+1];
    logic signed [CW-1:0] x_reg    [STAGES+1][LANES];
    logic signed [CW-1:0] y_reg    [STAGES+1][LANES];
    logic [31:0]          z_reg    [STAGES+1][LANES];
    logic                 zero_reg [STAGES+1][LANES];

    for (genvar k = 0; k <= STAGES; k++) begin : g_stage
        logic              cur_v;
        logic [SIDE_W-1:0] cur_side;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_v    = v_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[k] <= cur_side;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic signed [CW-1:0] x_next;
            logic signed [CW-1:0] y_next;
            logic [31:0]          z_next;
            logic                 zero_next;

            if (k == 0) begin : g_pre
                logic signed [CW-1:0] xe;
                logic signed [CW-1:0] ye;
                assign xe = CW'(in_x[l]) <<< 20;
                assign ye = CW'(in_y[l]) <<< 20;
                // fold the left half-plane over by half a turn
                always_comb begin
                    zero_next = (in_x[l] == '0) && (in_y[l] == '0);
                    if (in_x[l] < 0) begin
                        x_next = -xe;
                        y_next = -ye;
                        z_next = 32'h8000_0000;
                    end else begin
                        x_next = xe;
                        y_next = ye;
                        z_next = 32'h0;
                    end
                end
            end else begin : g_iter
                logic signed [CW-1:0] xs;
                logic signed [CW-1:0] ys;
                assign xs = x_reg[k-1][l] >>> (k - 1);
                assign ys = y_reg[k-1][l] >>> (k - 1);
                always_comb begin
                    zero_next = zero_reg[k-1][l];
                    if (!y_reg[k-1][l][CW-1]) begin
                        x_next = x_reg[k-1][l] + ys;
                        y_next = y_reg[k-1][l] - xs;
                        z_next = z_reg[k-1][l] + ATAN_TURNS[k-1];
                    end else begin
                        x_next = x_reg[k-1][l] - ys;
                        y_next = y_reg[k-1][l] + xs;
                        z_next = z_reg[k-1][l] - ATAN_TURNS[k-1];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[k][l]    <= x_next;
                    y_reg[k][l]    <= y_next;
                    z_reg[k][l]    <= z_next;
                    zero_reg[k][l] <= zero_next;
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_ang[l] = zero_reg[STAGES][l] ? 32'h0 : z_reg[STAGES][l];
        assign out_mag[l] = (zero_reg[STAGES][l] || x_reg[STAGES][l][CW-1]) ?
                            '0 : x_reg[STAGES][l][CW-2:0];
    end

    assign out_valid = v_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

// File: rtl/gfpb_amount.sv
// Gradient amount pipeline: geometry, CORDIC, ratio division and reversal to a Q1.16 t.
module gfpb_amount #(
    parameter int COORD_BITS    = gfpb_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = gfpb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  gfpb_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  gfpb_pkg::pix_t        in_pix,
    output logic                  out_valid,
    output logic [16:0]           out_t,
    output gfpb_pkg::pix_t        out_pix
);
    import gfpb_pkg::*;

    localparam int CXW  = COORD_BITS + 8;
    localparam int RW   = ((CXW > 24) ? CXW : 24) + 2;
    localparam int DW   = 25;
    localparam int PW   = RW + DW;
    localparam int DOTW = PW + 1;
    localparam int SUMW = DOTW;
    localparam int LSQW = 2 * DW;
    localparam int MW   = RW + 22;
    localparam int NW1  = (SUMW > LSQW) ? SUMW : LSQW;
    localparam int NW   = (NW1 > MW) ? NW1 : MW;
    localparam int QB   = 17;

    typedef struct packed {
        pix_t            pix;
        logic            degen;
        logic [SUMW-1:0] num;
        logic [LSQW-1:0] lsq;
    } cside_t;

    typedef struct packed {
        pix_t        pix;
        logic        degen;
        logic        angle;
        logic [15:0] tang;
        logic        zero;
        logic        full;
    } dside_t;

    // stage 1: offsets from the start point
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    pix_t                 pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix6_reg;
    logic signed [RW-1:0] rx1_reg, ry1_reg, rx2_reg, ry2_reg, rx3_reg, ry3_reg;
    logic signed [RW-1:0] rx4_reg, ry4_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;
    logic                 degen1_reg, degen2_reg, degen3_reg, degen4_reg;
    logic signed [PW-1:0] p_rxdx2_reg, p_rydy2_reg, p_dxry2_reg, p_dyrx2_reg;
    logic [LSQW-1:0]      p_dxdx2_reg, p_dydy2_reg;
    logic signed [DOTW-1:0] dot3_reg, cr3_reg;
    logic [LSQW-1:0]      lsq3_reg, lsq4_reg;
    logic [SUMW-1:0]      num4_reg;
    logic [16:0]          t6_reg;
    logic [SUMW-1:0]      num4_next, adot, acr;

    logic signed [RW-1:0] rx1_next, ry1_next;
    logic signed [DW-1:0] dx1_next, dy1_next;
    logic signed [23:0]   sx, sy, ex, ey;
    logic [CXW-1:0]       cx, cy;

    assign sx = cfg.start_point[23:0];
    assign sy = cfg.start_point[47:24];
    assign ex = cfg.end_point[23:0];
    assign ey = cfg.end_point[47:24];
    assign cx = {in_x, 8'h80};
    assign cy = {in_y, 8'h80};

    assign rx1_next = $signed({{(RW-CXW){1'b0}}, cx}) - RW'(sx);
    assign ry1_next = $signed({{(RW-CXW){1'b0}}, cy}) - RW'(sy);
    assign dx1_next = DW'(ex) - DW'(sx);
    assign dy1_next = DW'(ey) - DW'(sy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pix1_reg   <= in_pix;
            rx1_reg    <= rx1_next;
            ry1_reg    <= ry1_next;
            dx1_reg    <= dx1_next;
            dy1_reg    <= dy1_next;
            degen1_reg <= cfg.start_point == cfg.end_point;

            // stage 2: products
            pix2_reg    <= pix1_reg;
            rx2_reg     <= rx1_reg;
            ry2_reg     <= ry1_reg;
            dx2_reg     <= dx1_reg;
            dy2_reg     <= dy1_reg;
            degen2_reg  <= degen1_reg;
            p_rxdx2_reg <= PW'(rx1_reg) * PW'(dx1_reg);
            p_rydy2_reg <= PW'(ry1_reg) * PW'(dy1_reg);
            p_dxry2_reg <= PW'(dx1_reg) * PW'(ry1_reg);
            p_dyrx2_reg <= PW'(dy1_reg) * PW'(rx1_reg);
            p_dxdx2_reg <= LSQW'(LSQW'(dx1_reg) * LSQW'(dx1_reg));
            p_dydy2_reg <= LSQW'(LSQW'(dy1_reg) * LSQW'(dy1_reg));

            // stage 3: dot, cross, squared length
            pix3_reg   <= pix2_reg;
            rx3_reg    <= rx2_reg;
            ry3_reg    <= ry2_reg;
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            degen3_reg <= degen2_reg;
            dot3_reg   <= DOTW'(p_rxdx2_reg) + DOTW'(p_rydy2_reg);
            cr3_reg    <= DOTW'(p_dxry2_reg) - DOTW'(p_dyrx2_reg);
            lsq3_reg   <= p_dxdx2_reg + p_dydy2_reg;

            // stage 4: numerator of the projection types
            pix4_reg   <= pix3_reg;
            rx4_reg    <= rx3_reg;
            ry4_reg    <= ry3_reg;
            dx4_reg    <= dx3_reg;
            dy4_reg    <= dy3_reg;
            degen4_reg <= degen3_reg;
            lsq4_reg   <= lsq3_reg;
            num4_reg   <= num4_next;
        end
    end

    assign adot = dot3_reg[DOTW-1] ? SUMW'(-dot3_reg) : SUMW'(dot3_reg);
    assign acr  = cr3_reg[DOTW-1]  ? SUMW'(-cr3_reg)  : SUMW'(cr3_reg);

    always_comb begin
        case (cfg.gradient_type)
            GT_REFLECTED: num4_next = adot;
            GT_DIAMOND:   num4_next = adot + acr;
            default:      num4_next = (dot3_reg[DOTW-1] || dot3_reg == '0) ?
                                      '0 : SUMW'(dot3_reg);
        endcase
    end

    // CORDIC on the pixel offset (lane 0) and the axis (lane 1)
    logic signed [RW-1:0] cx_in [2];
    logic signed [RW-1:0] cy_in [2];
    logic [31:0]          c_ang [2];
    logic [MW-1:0]        c_mag [2];
    cside_t               cs_in, cs_out;
    logic                 c_valid;

    assign cx_in[0] = rx4_reg;
    assign cy_in[0] = ry4_reg;
    assign cx_in[1] = RW'(dx4_reg);
    assign cy_in[1] = RW'(dy4_reg);
    assign cs_in    = '{pix: pix4_reg, degen: degen4_reg, num: num4_reg, lsq: lsq4_reg};

    gfpb_cordic #(
        .STAGES (CORDIC_STAGES),
        .IN_W   (RW),
        .LANES  (2),
        .SIDE_W ($bits(cside_t))
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_x      (cx_in),
        .in_y      (cy_in),
        .in_side   (cs_in),
        .out_valid (c_valid),
        .out_ang   (c_ang),
        .out_mag   (c_mag),
        .out_side  (cs_out)
    );

    // stage 5: pick numerator and denominator, catch the clamped cases
    logic [NW-1:0]  num5, den5;
    logic [NW-1:0]  hi5_reg [1];
    logic [NW-1:0]  den5_reg [1];
    logic [QB-1:0]  lo5 [1];
    logic [31:0]    adiff;
    dside_t         ds5_reg, ds_out;
    logic [QB-1:0]  q_out [1];
    logic           d_valid;

    always_comb begin
        if (cfg.gradient_type == GT_RADIAL) begin
            num5 = NW'(c_mag[0]);
            den5 = NW'(c_mag[1]);
        end else begin
            num5 = NW'(cs_out.num);
            den5 = NW'(cs_out.lsq);
        end
    end

    assign adiff  = c_ang[0] - c_ang[1];
    assign lo5[0] = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (ce) begin
            v5_reg <= c_valid;
            v6_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hi5_reg[0]    <= (num5 >= den5) ? '0 : num5;
            den5_reg[0]   <= den5;
            ds5_reg.pix   <= cs_out.pix;
            ds5_reg.degen <= cs_out.degen;
            ds5_reg.angle <= cfg.gradient_type == GT_ANGLE;
            ds5_reg.tang  <= adiff[31:16];
            ds5_reg.zero  <= num5 == '0;
            ds5_reg.full  <= num5 >= den5;
        end
    end

    gfpb_div #(
        .DEN_W  (NW),
        .Q_BITS (QB),
        .LANES  (1),
        .SIDE_W ($bits(dside_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v5_reg),
        .in_hi     (hi5_reg),
        .in_lo     (lo5),
        .in_den    (den5_reg),
        .in_side   (ds5_reg),
        .out_valid (d_valid),
        .out_q     (q_out),
        .out_side  (ds_out)
    );

    // stage 6: round, clamp and reverse
    logic [16:0] t_raw, t_rnd;

    assign t_rnd = 17'((18'(q_out[0]) + 18'd1) >> 1);

    always_comb begin
        if (ds_out.degen) begin
            t_raw = 17'(ONE_Q16);
        end else if (ds_out.angle) begin
            t_raw = {1'b0, ds_out.tang};
        end else if (ds_out.zero) begin
            t_raw = '0;
        end else if (ds_out.full) begin
            t_raw = 17'(ONE_Q16);
        end else begin
            t_raw = t_rnd;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t6_reg   <= cfg.reverse_direction ? 17'(ONE_Q16) - t_raw : t_raw;
            pix6_reg <= ds_out.pix;
        end
    end

    assign out_valid = v6_reg;
    assign out_t     = t6_reg;
    assign out_pix   = pix6_reg;

endmodule

// File: rtl/gfpb_blend.sv
// Colour pipeline: gradient colour, straight-alpha compositing or grey blends, output register.
module gfpb_blend (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  gfpb_pkg::cfg_t cfg,
    input  logic           in_valid,
    input  logic [16:0]    in_t,
    input  gfpb_pkg::pix_t in_pix,
    output logic           out_valid,
    output gfpb_pkg::res_t out_res
);
    import gfpb_pkg::*;

    typedef struct packed {
        pix_t            pix;
        logic [7:0]      alpha;
        logic [3:0][7:0] grey;
    } bside_t;

    function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [16:0] t);
        logic signed [9:0]  diff;
        logic signed [27:0] prod;
        logic signed [27:0] v;
        diff = $signed({2'b0, b}) - $signed({2'b0, a});
        prod = 28'(diff) * $signed({11'b0, t});
        v    = $signed({4'b0, a, 16'b0}) + prod + 28'sd32768;
        return (v[27:24] != 4'b0) ? 8'd255 : v[23:16];
    endfunction

    function automatic logic [7:0] grey_of(input logic [31:0] c);
        logic [12:0] s;
        s = 13'(c[7:0]) * 13'd11 + 13'(c[15:8]) * 13'd16 + 13'(c[23:16]) * 13'd5;
        return s[12:5];
    endfunction

    logic            v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    pix_t            pix1_reg, pix2_reg, pix3_reg, pix4_reg;
    logic [3:0][7:0] des1_reg;
    logic [7:0]      g1_reg;
    logic [15:0]     wa2_reg, wd2_reg;
    logic [15:0]     ba2_reg [3];
    logic [15:0]     dd2_reg [3];
    logic [15:0]     gs2_reg [4];
    logic [15:0]     n3_reg;
    logic [23:0]     p3_reg [3];
    logic [3:0][7:0] grey3_reg, grey4_reg;
    logic [7:0]      alpha4_reg;
    logic [16:0]     hi4_reg [3];
    logic [7:0]      lo4_reg [3];
    logic [16:0]     den4_reg [3];
    res_t            out_res_reg;
    logic [24:0]     num4 [3];
    logic            d_valid;

    logic [7:0] gs_start, gs_end, inv1, inv2;
    logic [7:0] bef1 [4];

    assign gs_start = grey_of(cfg.start_colour);
    assign gs_end   = grey_of(cfg.end_colour);
    assign inv1     = 8'd255 - pix1_reg.coverage;
    assign inv2     = 8'd255 - pix2_reg.coverage;
    assign bef1[0]  = pix1_reg.red;
    assign bef1[1]  = pix1_reg.green;
    assign bef1[2]  = pix1_reg.blue;
    assign bef1[3]  = pix1_reg.alpha;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // B1: gradient colour and grey at t
            pix1_reg <= in_pix;
            for (int c = 0; c < 4; c++) begin
                des1_reg[c] <= lerp(cfg.start_colour[8*c +: 8], cfg.end_colour[8*c +: 8], in_t);
            end
            g1_reg <= lerp(gs_start, gs_end, in_t);

            // B2: first-level products
            pix2_reg <= pix1_reg;
            wa2_reg  <= 16'(pix1_reg.alpha) * 16'(inv1);
            wd2_reg  <= 16'(des1_reg[3]) * 16'(pix1_reg.coverage);
            for (int c = 0; c < 3; c++) begin
                ba2_reg[c] <= 16'(bef1[c]) * 16'(pix1_reg.alpha);
                dd2_reg[c] <= 16'(des1_reg[c]) * 16'(des1_reg[3]);
            end
            for (int c = 0; c < 4; c++) begin
                gs2_reg[c] <= 16'(bef1[c]) * 16'(inv1) + 16'(g1_reg) * 16'(pix1_reg.coverage)
                              + 16'd127;
            end

            // B3: weighted sums
            pix3_reg <= pix2_reg;
            n3_reg   <= wa2_reg + wd2_reg;
            for (int c = 0; c < 3; c++) begin
                p3_reg[c] <= 24'(ba2_reg[c]) * 24'(inv2) + 24'(dd2_reg[c]) * 24'(pix2_reg.coverage);
            end
            for (int c = 0; c < 4; c++) begin
                grey3_reg[c] <= div255(gs2_reg[c]);
            end

            // B4: composite alpha and rounded quotient operands
            pix4_reg   <= pix3_reg;
            grey4_reg  <= grey3_reg;
            alpha4_reg <= div255(n3_reg + 16'd127);
            for (int c = 0; c < 3; c++) begin
                hi4_reg[c]  <= num4[c][24:8];
                lo4_reg[c]  <= num4[c][7:0];
                den4_reg[c] <= {n3_reg, 1'b0};
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num4[c] = {p3_reg[c], 1'b0} + 25'(n3_reg);
        end
    end

    bside_t     bs_in, bs_out;
    logic [7:0] q_out [3];

    assign bs_in = '{pix: pix4_reg, alpha: alpha4_reg, grey: grey4_reg};

    gfpb_div #(
        .DEN_W  (17),
        .Q_BITS (8),
        .LANES  (3),
        .SIDE_W ($bits(bside_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_hi     (hi4_reg),
        .in_lo     (lo4_reg),
        .in_den    (den4_reg),
        .in_side   (bs_in),
        .out_valid (d_valid),
        .out_q     (q_out),
        .out_side  (bs_out)
    );

    // B5: pick by target mode
    res_t res_next;
    pix_t bp;

    assign bp = bs_out.pix;

    always_comb begin
        res_next.red   = bp.red;
        res_next.green = bp.green;
        res_next.blue  = bp.blue;
        res_next.alpha = bp.alpha;
        if (bp.coverage != 8'd0) begin
            case (cfg.target_mode)
                TM_RASTER: begin
                    res_next.alpha = bs_out.alpha;
                    // fully transparent result keeps the old colour
                    if (bs_out.alpha != 8'd0) begin
                        res_next.red   = q_out[0];
                        res_next.green = q_out[1];
                        res_next.blue  = q_out[2];
                    end
                end
                TM_GREY_RGB: begin
                    res_next.red   = bs_out.grey[0];
                    res_next.green = bs_out.grey[1];
                    res_next.blue  = bs_out.grey[2];
                end
                TM_GREY_ONE: begin
                    case (cfg.component_index)
                        CI_RED:   res_next.red   = bs_out.grey[0];
                        CI_GREEN: res_next.green = bs_out.grey[1];
                        CI_BLUE:  res_next.blue  = bs_out.grey[2];
                        default:  res_next.alpha = bs_out.grey[3];
                    endcase
                end
                default: begin
                    res_next.red = bs_out.grey[0];
                end
            endcase
        end
        res_next.changed = (res_next.red != bp.red) || (res_next.green != bp.green) ||
                           (res_next.blue != bp.blue) || (res_next.alpha != bp.alpha);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// File: tb/gfpb_checker.sv
// Scoreboard for the gradient fill block: tracks the registers, predicts each pixel and compares.
module gfpb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fails,
    output int          pending
);
    import gfpb_pkg::*;

    typedef struct {
        logic [7:0] red, green, blue, alpha;
        logic       changed;
    } fill_res_t;

    logic [47:0] start_pt, end_pt;
    logic [31:0] start_col, end_col;
    logic [2:0]  grad_kind;
    logic        reverse;
    logic [1:0]  tgt_mode, comp_sel;

    fill_res_t filled_q[$];

    function automatic longint sext24(input logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint frac16(input longint num, input longint den);
        longint rem, q;
        rem = num;
        q = 0;
        for (int i = 0; i < 17; i++) begin
            rem = rem <<< 1;
            q = q <<< 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
        end
        return (q + 1) >>> 1;
    endfunction

    function automatic longint ratio16(input longint num, input longint den);
        if (num == 0) return 0;
        if (num >= den) return ONE_Q16;
        return frac16(num, den);
    endfunction

    function automatic void cordic_vec(input longint xi, input longint yi,
                                       output logic [31:0] ang, output longint mag);
        longint x, y, xs, ys;
        logic [31:0] z;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            mag = 0;
            return;
        end
        x = x * 1048576;
        y = y * 1048576;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_TURNS[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TURNS[i];
            end
        end
        ang = z;
        mag = (x < 0) ? 0 : x;
    endfunction

    function automatic longint amount_at(input longint px, input longint py);
        longint sx, sy, dx, dy, rx, ry, lsq, dot, crs, t, m1, m2;
        logic [31:0] a1, a2, ad;
        sx = sext24(start_pt[23:0]);
        sy = sext24(start_pt[47:24]);
        dx = sext24(end_pt[23:0]) - sx;
        dy = sext24(end_pt[47:24]) - sy;
        rx = px * 256 + 128 - sx;
        ry = py * 256 + 128 - sy;
        lsq = dx * dx + dy * dy;
        dot = rx * dx + ry * dy;
        crs = dx * ry - dy * rx;
        if (dx == 0 && dy == 0) begin
            t = ONE_Q16;
        end else begin
            case (grad_kind)
                GT_RADIAL: begin
                    cordic_vec(rx, ry, a1, m1);
                    cordic_vec(dx, dy, a2, m2);
                    t = ratio16(m1, m2);
                end
                GT_ANGLE: begin
                    cordic_vec(rx, ry, a1, m1);
                    cordic_vec(dx, dy, a2, m2);
                    ad = a1 - a2;
                    t = longint'(ad[31:16]);
                end
                GT_REFLECTED: t = ratio16((dot < 0) ? -dot : dot, lsq);
                GT_DIAMOND: t = ratio16(((dot < 0) ? -dot : dot) + ((crs < 0) ? -crs : crs), lsq);
                default: t = (dot <= 0) ? 0 : ratio16(dot, lsq);
            endcase
        end
        return reverse ? ONE_Q16 - t : t;
    endfunction

    function automatic longint lerp8(input longint a, input longint b, input longint t);
        longint v;
        v = (a * 65536 + (b - a) * t + 32768) >>> 16;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic longint mix8(input longint bef, input longint aft, input longint m);
        longint r;
        r = (bef * (255 - m) + aft * m + 127) / 255;
        return (r > 255) ? 255 : r;
    endfunction

    function automatic longint grey_of(input logic [31:0] c);
        return (longint'(c[7:0]) * 11 + longint'(c[15:8]) * 16 + longint'(c[23:16]) * 5) / 32;
    endfunction

    function automatic fill_res_t fill_pixel(input logic [71:0] w);
        longint bef[4], aft[4], des[4], m, t, n, p, g;
        fill_res_t r;
        m = w[35:28];
        for (int c = 0; c < 4; c++) begin
            bef[c] = w[36 + 8*c +: 8];
            aft[c] = bef[c];
        end
        if (m != 0) begin
            t = amount_at(longint'(w[13:0]), longint'(w[27:14]));
            if (tgt_mode == TM_RASTER) begin
                for (int c = 0; c < 4; c++)
                    des[c] = lerp8(start_col[8*c +: 8], end_col[8*c +: 8], t);
                n = bef[3] * (255 - m) + des[3] * m;
                aft[3] = (n + 127) / 255;
                if (aft[3] > 255) aft[3] = 255;
                if (aft[3] > 0) begin
                    for (int c = 0; c < 3; c++) begin
                        p = bef[c] * bef[3] * (255 - m) + des[c] * des[3] * m;
                        aft[c] = (2 * p + n) / (2 * n);
                        if (aft[c] > 255) aft[c] = 255;
                    end
                end
            end else begin
                g = lerp8(grey_of(start_col), grey_of(end_col), t);
                if (tgt_mode == TM_GREY_RGB) begin
                    for (int c = 0; c < 3; c++) aft[c] = mix8(bef[c], g, m);
                end else if (tgt_mode == TM_GREY_ONE) begin
                    aft[comp_sel] = mix8(bef[comp_sel], g, m);
                end else begin
                    aft[0] = mix8(bef[0], g, m);
                end
            end
        end
        r.red   = aft[0][7:0];
        r.green = aft[1][7:0];
        r.blue  = aft[2][7:0];
        r.alpha = aft[3][7:0];
        r.changed = (aft[0] != bef[0]) || (aft[1] != bef[1]) ||
                    (aft[2] != bef[2]) || (aft[3] != bef[3]);
        return r;
    endfunction

    always @(posedge aclk) begin
        fill_res_t e;
        int delta;
        int nerr;
        delta = 0;
        nerr = 0;
        if (!aresetn) begin
            start_pt  <= '0;
            end_pt    <= '0;
            start_col <= '0;
            end_col   <= 32'hFFFF_FFFF;
            grad_kind <= GT_LINEAR;
            reverse   <= 1'b0;
            tgt_mode  <= TM_RASTER;
            comp_sel  <= CI_RED;
            filled_q.delete();
            pending   <= 0;
            fails     <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_START_POINT:  start_pt  <= pwdata[47:0];
                    REG_END_POINT:    end_pt    <= pwdata[47:0];
                    REG_START_COLOUR: start_col <= pwdata[31:0];
                    REG_END_COLOUR:   end_col   <= pwdata[31:0];
                    REG_GRAD_TYPE:    grad_kind <= pwdata[2:0];
                    REG_REVERSE:      reverse   <= pwdata[0];
                    REG_TARGET_MODE:  tgt_mode  <= pwdata[1:0];
                    REG_COMPONENT:    comp_sel  <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                filled_q.push_back(fill_pixel(s_tdata));
                delta++;
            end
            if (m_tvalid && m_tready) begin
                if (filled_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    nerr++;
                end else begin
                    e = filled_q.pop_front();
                    delta--;
                    if (m_tdata[7:0] !== e.red) begin
                        $error("out_red exp %0d got %0d", e.red, m_tdata[7:0]);
                        nerr++;
                    end
                    if (m_tdata[15:8] !== e.green) begin
                        $error("out_green exp %0d got %0d", e.green, m_tdata[15:8]);
                        nerr++;
                    end
                    if (m_tdata[23:16] !== e.blue) begin
                        $error("out_blue exp %0d got %0d", e.blue, m_tdata[23:16]);
                        nerr++;
                    end
                    if (m_tdata[31:24] !== e.alpha) begin
                        $error("out_alpha exp %0d got %0d", e.alpha, m_tdata[31:24]);
                        nerr++;
                    end
                    if (m_tdata[32] !== e.changed) begin
                        $error("pixel_changed exp %0d got %0d", e.changed, m_tdata[32]);
                        nerr++;
                    end
                end
            end
            pending <= pending + delta;
            fails   <= fails + nerr;
        end
    end
endmodule

// File: tb/tb_top.sv
// Testbench top: clock, reset, register set-up, pixel stimulus and verdict.
module tb_top;
    import gfpb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // pixel_x, pixel_y, coverage, in_red, in_green, in_blue, in_alpha, zero pad
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha, pixel_changed, zero pad
    logic [39:0] m_tdata;
    int          fails, pending;
    int          cycles = 0;
    bit          rx_steady = 1'b0;
    bit          near_pix = 1'b1;

    always #6 aclk = ~aclk;

    gradient_fill_pixel_blend u_top (.*);

    gfpb_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: stretches of steady acceptance, otherwise random stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) rx_steady <= ~rx_steady;
        if (rx_steady) m_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 9) == 0) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending, then wait until every word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic send_word(input logic [13:0] x, input logic [13:0] y, input logic [7:0] cov,
                             input logic [31:0] rgba);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0], cov, y, x};
        do @(posedge aclk); while (!s_tready);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_random();
        logic [13:0] x, y;
        logic [7:0]  cov;
        int r;
        x = near_pix ? 14'($urandom_range(0, 110)) : 14'($urandom);
        y = near_pix ? 14'($urandom_range(0, 110)) : 14'($urandom);
        if ($urandom_range(0, 9) == 0) x = 14'($urandom);
        r = $urandom_range(0, 9);
        cov = (r == 0) ? 8'd0 : (r < 3) ? 8'd255 : 8'($urandom);
        send_word(x, y, cov, $urandom);
    endtask

    function automatic logic [23:0] coord24();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 24'h7F_FFFF;
        if (r == 1) return 24'h80_0000;
        if (r == 2) return 24'($urandom);
        if (r == 3) return -24'($urandom_range(0, 40 * 256));
        return 24'($urandom_range(0, 110 * 256));
    endfunction

    function automatic logic [31:0] colour32();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    initial begin
        logic [47:0] sp, ep;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: start equals end, so the amount is one everywhere
        send_word(14'd0, 14'd0, 8'd255, 32'h0);
        send_word(14'h3FFF, 14'h3FFF, 8'd0, 32'hFFFF_FFFF);
        send_word(14'd5, 14'd9, 8'd128, 32'h8040_2010);
        send_word(14'h2AAA, 14'h1555, 8'd1, 32'h00FF_00FF);
        drain();

        // horizontal ramp, each target mode in turn with the angle, radial or diamond type
        apb_write(REG_START_POINT, 64'h0);
        apb_write(REG_END_POINT, {40'h0, 24'd64 * 24'd256});
        apb_write(REG_START_COLOUR, 64'h00FF_0000);
        apb_write(REG_END_COLOUR, 64'hFF00_FFFF);
        for (int k = 0; k < 4; k++) begin
            apb_write(REG_TARGET_MODE, 64'(k));
            apb_write(REG_GRAD_TYPE, 64'((k == 0) ? GT_ANGLE : (k == 1) ? GT_RADIAL : GT_DIAMOND));
            apb_write(REG_COMPONENT, 64'(CI_ALPHA));
            apb_write(REG_REVERSE, 64'(k & 1));
            send_word(14'd0, 14'd0, 8'd255, 32'h0000_00FF);
            send_word(14'd32, 14'd0, 8'd200, 32'h8080_8080);
            send_word(14'd100, 14'd3, 8'd255, 32'h0000_0000);
            send_word(14'h3FFF, 14'd0, 8'd77, 32'hFFFF_FFFF);
            drain();
        end

        for (int ph = 0; ph < 30; ph++) begin
            sp = {coord24(), coord24()};
            ep = ($urandom_range(0, 9) == 0) ? sp : {coord24(), coord24()};
            near_pix = ($urandom_range(0, 4) != 0);
            apb_write(REG_START_POINT, 64'(sp));
            apb_write(REG_END_POINT, 64'(ep));
            apb_write(REG_START_COLOUR, 64'(colour32()));
            apb_write(REG_END_COLOUR, 64'(colour32()));
            apb_write(REG_GRAD_TYPE, 64'((ph < 8) ? ph : $urandom_range(0, 7)));
            apb_write(REG_REVERSE, 64'($urandom_range(0, 1)));
            apb_write(REG_TARGET_MODE, 64'($urandom_range(0, 3)));
            apb_write(REG_COMPONENT, 64'($urandom_range(0, 3)));
            for (int i = 0; i < 24; i++) begin
                send_random();
                // hold off once mid-phase until everything has come back
                if (ph == 10 && i == 12) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    drain();
                end
            end
            s_tvalid <= 1'b0;
            @(posedge aclk);
            drain();
        end

        repeat (80) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
